// File: design/tile_row_line_composer_macros.svh
// assertion macros for the tile row line composer
// no dependencies; included by the files that carry checks
`ifndef TILE_ROW_LINE_COMPOSER_MACROS_SVH
`define TILE_ROW_LINE_COMPOSER_MACROS_SVH

`ifndef SYNTHESIS
// same-cycle implication, held off during reset
`define TRLC_ASSERT_IMPLIES(label, clk, rst, cond, expr) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (expr)) \
    else $error("trlc: same-cycle check failed");
// next-cycle implication, held off during reset
`define TRLC_ASSERT_NEXT(label, clk, rst, cond, expr) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (expr)) \
    else $error("trlc: next-cycle check failed");
`else
`define TRLC_ASSERT_IMPLIES(label, clk, rst, cond, expr)
`define TRLC_ASSERT_NEXT(label, clk, rst, cond, expr)
`endif

`endif

// File: design/trlc_pkg.sv
// shared types and constants of the tile row line composer
// no dependencies; imported by every module of the block
package trlc_pkg;

  localparam int TILE_PIXELS      = 8;
  localparam int PIXEL_INDEX_BITS = 2;
  localparam int ROW_W            = 16;
  localparam int POS_W            = 9;
  localparam int COLOR_W          = 8;
  localparam int FS_W             = 3;
  localparam int LT_W             = 7;
  localparam int PX_W             = 4;   // holds a pixel count 0..8
  localparam int CNT_EXT_W        = 8;   // holds a tile total up to 128
  localparam int CFG_IDX_W        = 1;
  localparam int CFG_DATA_W       = 7;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_FINE_SCROLL = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LINE_TILES  = 1'd1;

  localparam logic [LT_W-1:0] LINE_TILES_RESET = 7'd32;

  // pixel index codes
  localparam logic [PIXEL_INDEX_BITS-1:0] IDX_CLEAR = 2'd0;
  localparam logic [PIXEL_INDEX_BITS-1:0] IDX_ONE   = 2'd1;
  localparam logic [PIXEL_INDEX_BITS-1:0] IDX_TWO   = 2'd2;

  typedef struct packed {
    logic               tile_present;
    logic [ROW_W-1:0]   pixel_row;
    logic [COLOR_W-1:0] color_one;
    logic [COLOR_W-1:0] color_two;
    logic [COLOR_W-1:0] color_three;
  } tile_t;

  typedef struct packed {
    logic [POS_W-1:0]   pixel_position;
    logic [COLOR_W-1:0] pixel_color;
    logic               write_enable;
    logic               last_of_tile;
    logic               last_of_line;
  } pixel_t;

  // per-tile span handed from the line tracker to the cells
  typedef struct packed {
    logic [FS_W-1:0]  first_px;
    logic [PX_W-1:0]  count;
    logic [POS_W-1:0] pos_base;
    logic             line_end;
  } desc_t;

endpackage

// File: design/trlc_tile_ctl.sv
// line tracker: tile count and line position, per-tile span decode
// depends on trlc_pkg
module trlc_tile_ctl #(
  parameter int MAX_TILES = 64
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         advance,
  input  logic [trlc_pkg::FS_W-1:0]    fine_scroll,
  input  logic [trlc_pkg::LT_W-1:0]    line_tiles,
  output trlc_pkg::desc_t              desc
);
  import trlc_pkg::*;

  localparam int CW = $clog2(MAX_TILES + 2);
  localparam logic [CNT_EXT_W-1:0] MAX_EXT = CNT_EXT_W'(MAX_TILES);

  logic [CW-1:0]        tile_count;
  logic [CW-1:0]        tile_count_next;
  logic [POS_W-1:0]     line_position;
  logic [POS_W-1:0]     line_position_next;

  logic [CNT_EXT_W-1:0] lt_ext;
  logic [CNT_EXT_W-1:0] eff;
  logic [CNT_EXT_W-1:0] total;
  logic [CNT_EXT_W-1:0] tc_ext;
  logic [CNT_EXT_W-1:0] cur;

  // clamp line length and find where this tile sits in the line
  always_comb begin
    lt_ext = CNT_EXT_W'(line_tiles);
    if (lt_ext == '0) begin
      eff = CNT_EXT_W'(1);
    end else if (lt_ext > MAX_EXT) begin
      eff = MAX_EXT;
    end else begin
      eff = lt_ext;
    end
    total  = eff + CNT_EXT_W'(fine_scroll != '0);
    tc_ext = CNT_EXT_W'(tile_count);
    cur    = (tc_ext >= total) ? '0 : tc_ext;
  end

  // span of pixels the tile covers
  always_comb begin
    desc.line_end = (cur + CNT_EXT_W'(1)) == total;
    if (cur == '0) begin
      desc.pos_base = '0;
      desc.first_px = fine_scroll;
      desc.count    = PX_W'(TILE_PIXELS) - PX_W'(fine_scroll);
    end else if (cur < eff) begin
      desc.pos_base = line_position;
      desc.first_px = '0;
      desc.count    = PX_W'(TILE_PIXELS);
    end else begin
      desc.pos_base = line_position;
      desc.first_px = '0;
      desc.count    = PX_W'(fine_scroll);
    end
  end

  // state after this tile
  always_comb begin
    if (desc.line_end) begin
      tile_count_next    = '0;
      line_position_next = '0;
    end else begin
      tile_count_next    = CW'(cur + CNT_EXT_W'(1));
      line_position_next = desc.pos_base + POS_W'(desc.count);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tile_count    <= '0;
      line_position <= '0;
    end else if (advance) begin
      tile_count    <= tile_count_next;
      line_position <= line_position_next;
    end
  end

endmodule

// File: design/trlc_cell.sv
// one pixel slot of the output chain: loads its pixel of a tile, shifts toward the head
// depends on trlc_pkg
module trlc_cell #(
  parameter int SLOT = 0
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             load,
  input  logic             shift,
  input  trlc_pkg::tile_t  tile,
  input  trlc_pkg::desc_t  desc,
  input  logic             neighbor_valid,
  input  trlc_pkg::pixel_t neighbor,
  output logic             valid,
  output trlc_pkg::pixel_t pixel
);
  import trlc_pkg::*;

  localparam int SH_W = 8;

  logic [PX_W-1:0]             p;
  logic [SH_W-1:0]             shamt;
  logic [ROW_W-1:0]            row_shifted;
  logic [PIXEL_INDEX_BITS-1:0] idx;
  logic                        load_valid;
  pixel_t                      lpix;

  // pick this slot's index out of the row
  always_comb begin
    p           = PX_W'(desc.first_px) + PX_W'(SLOT);
    shamt       = SH_W'(p) * SH_W'(PIXEL_INDEX_BITS);
    row_shifted = tile.pixel_row >> shamt;
    idx         = row_shifted[PIXEL_INDEX_BITS-1:0];
    load_valid  = PX_W'(SLOT) < desc.count;
  end

  // palette lookup and tile/line marks
  always_comb begin
    lpix.pixel_position = desc.pos_base + POS_W'(SLOT);
    lpix.last_of_tile   = PX_W'(SLOT + 1) == desc.count;
    lpix.last_of_line   = lpix.last_of_tile && desc.line_end;
    if (!tile.tile_present || idx == IDX_CLEAR) begin
      lpix.write_enable = 1'b0;
      lpix.pixel_color  = '0;
    end else if (idx == IDX_ONE) begin
      lpix.write_enable = 1'b1;
      lpix.pixel_color  = tile.color_one;
    end else if (idx == IDX_TWO) begin
      lpix.write_enable = 1'b1;
      lpix.pixel_color  = tile.color_two;
    end else begin
      lpix.write_enable = 1'b1;
      lpix.pixel_color  = tile.color_three;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (load) begin
      valid <= load_valid;
    end else if (shift) begin
      valid <= neighbor_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      pixel <= lpix;
    end else if (shift) begin
      pixel <= neighbor;
    end
  end

endmodule

// File: design/tile_row_line_composer.sv
// Tile row line composer: turns a stream of 8-pixel tile rows into one line-buffer write
// beat per covered pixel position, with horizontal fine scroll (first tile of a line drops
// fine_scroll pixels, an extra closing tile gives fine_scroll pixels). A tile is held in a
// one-entry input register, then loaded into a chain of eight pixel cells that shift one
// pixel per cycle to the output head unless the output stalls. A tile gives one beat per
// pixel it covers: 8 for a middle tile, 8 - fine_scroll for the first and fine_scroll
// for the extra tile, with no gap between tiles while the output is not stalled; the
// next tile is accepted while the current one drains. No clearing pass after reset.
// Depends on trlc_pkg, trlc_tile_ctl, trlc_cell and the macro header.
`include "tile_row_line_composer_macros.svh"

module tile_row_line_composer #(
  parameter int MAX_TILES = 64
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              tile_valid,
  output logic                              tile_stall,
  input  trlc_pkg::tile_t                   tile_beat,
  output logic                              pixel_valid,
  input  logic                              pixel_stall,
  output trlc_pkg::pixel_t                  pixel_beat,
  input  logic                              cfg_we,
  input  logic [trlc_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [trlc_pkg::CFG_DATA_W-1:0]   cfg_data
);
  import trlc_pkg::*;

  localparam int CELLS = TILE_PIXELS;

  logic [FS_W-1:0]  fine_scroll;
  logic [LT_W-1:0]  line_tiles;

  logic             buf_valid;
  tile_t            tile_buf;
  desc_t            desc;

  logic [CELLS-1:0] chain_valid;
  pixel_t           chain_pixel [CELLS];
  logic [CELLS-1:0] nb_valid;
  pixel_t           nb_pixel    [CELLS];

  logic             take;
  logic             load;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      fine_scroll <= '0;
      line_tiles  <= LINE_TILES_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_FINE_SCROLL: fine_scroll <= cfg_data[FS_W-1:0];
        REG_LINE_TILES:  line_tiles  <= cfg_data[LT_W-1:0];
        default: ;
      endcase
    end
  end

  // handshake: chain head is the output, load when the chain drains this cycle
  assign pixel_valid = chain_valid[0];
  assign pixel_beat  = chain_pixel[0];
  assign take        = chain_valid[0] && !pixel_stall;
  assign load        = buf_valid && (!chain_valid[0] || (take && !chain_valid[1]));
  assign tile_stall  = buf_valid && !load;

  // one-entry input register
  always_ff @(posedge clk) begin
    if (rst) begin
      buf_valid <= 1'b0;
    end else if (tile_valid && !tile_stall) begin
      buf_valid <= 1'b1;
    end else if (load) begin
      buf_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (tile_valid && !tile_stall) begin
      tile_buf <= tile_beat;
    end
  end

  // line position and tile count
  trlc_tile_ctl #(
    .MAX_TILES (MAX_TILES)
  ) u_tile_ctl (
    .clk         (clk),
    .rst         (rst),
    .advance     (load),
    .fine_scroll (fine_scroll),
    .line_tiles  (line_tiles),
    .desc        (desc)
  );

  // pixel cell chain, each cell fed by the one above it
  for (genvar k = 0; k < CELLS; k++) begin : g_cell
    if (k == CELLS - 1) begin : g_tail
      assign nb_valid[k] = 1'b0;
      assign nb_pixel[k] = '0;
    end else begin : g_mid
      assign nb_valid[k] = chain_valid[k+1];
      assign nb_pixel[k] = chain_pixel[k+1];
    end

    trlc_cell #(
      .SLOT (k)
    ) u_cell (
      .clk            (clk),
      .rst            (rst),
      .load           (load),
      .shift          (take),
      .tile           (tile_buf),
      .desc           (desc),
      .neighbor_valid (nb_valid[k]),
      .neighbor       (nb_pixel[k]),
      .valid          (chain_valid[k]),
      .pixel          (chain_pixel[k])
    );
  end

  // checks
  `TRLC_ASSERT_IMPLIES(a_chain_packed, clk, rst, !chain_valid[0], chain_valid == '0)
  `TRLC_ASSERT_IMPLIES(a_load_when_drained, clk, rst, load, !chain_valid[1])
  `TRLC_ASSERT_NEXT(a_load_fills_head, clk, rst, load, chain_valid[0])
  `TRLC_ASSERT_IMPLIES(a_tile_rest_queued, clk, rst, take && !pixel_beat.last_of_tile, chain_valid[1])

endmodule

// File: verif/tile_row_line_composer_tb.sv
`timescale 1ns / 1ps
// self-checking testbench for the tile row line composer: tile beats in, pixel beats out
// depends on trlc_pkg and the tile_row_line_composer rtl

// predicts the pixel beats of each accepted tile and checks the beats that come out
class line_scoreboard;
  localparam int LINE_TILES_MAX = 64;

  logic [trlc_pkg::FS_W-1:0]  fine_scroll;
  logic [trlc_pkg::LT_W-1:0]  line_tiles;
  int unsigned                tile_count;
  logic [trlc_pkg::POS_W-1:0] line_position;
  trlc_pkg::pixel_t           pending_pixels[$];
  int                         errors;
  int                         pixels_checked;
  int                         tiles_seen;
  int                         max_position;

  function new();
    fine_scroll    = '0;
    line_tiles     = trlc_pkg::LINE_TILES_RESET;
    tile_count     = 0;
    line_position  = '0;
    errors         = 0;
    pixels_checked = 0;
    tiles_seen     = 0;
    max_position   = 0;
  endfunction

  function void set_reg(logic [trlc_pkg::CFG_IDX_W-1:0] idx,
                        logic [trlc_pkg::CFG_DATA_W-1:0] data);
    if (idx == trlc_pkg::REG_FINE_SCROLL) begin
      fine_scroll = data[trlc_pkg::FS_W-1:0];
    end else if (idx == trlc_pkg::REG_LINE_TILES) begin
      line_tiles = data[trlc_pkg::LT_W-1:0];
    end
  endfunction

  // work out the pixel beats one tile covers and queue them
  function void add_tile(trlc_pkg::tile_t t);
    int unsigned span;
    int unsigned total;
    int unsigned first_px;
    int unsigned count;
    bit          line_end;
    logic [trlc_pkg::PIXEL_INDEX_BITS-1:0] pix_idx;
    trlc_pkg::pixel_t px;
    tiles_seen++;
    // out-of-range line lengths are clamped
    span = int'(line_tiles);
    if (span < 1) span = 1;
    if (span > LINE_TILES_MAX) span = LINE_TILES_MAX;
    total = span + ((fine_scroll != 0) ? 1 : 0);
    // line shortened under a running count restarts the line
    if (tile_count >= total) begin
      tile_count    = 0;
      line_position = '0;
    end
    if (tile_count == 0) begin
      line_position = '0;
      first_px      = int'(fine_scroll);
      count         = trlc_pkg::TILE_PIXELS - int'(fine_scroll);
    end else if (tile_count < span) begin
      first_px = 0;
      count    = trlc_pkg::TILE_PIXELS;
    end else begin
      first_px = 0;
      count    = int'(fine_scroll);
    end
    line_end = (tile_count + 1 == total);
    for (int k = 0; k < count; k++) begin
      pix_idx = t.pixel_row[(first_px + k) * trlc_pkg::PIXEL_INDEX_BITS +:
                            trlc_pkg::PIXEL_INDEX_BITS];
      px = '0;
      px.pixel_position = line_position;
      // transparent index and absent tile leave the buffer alone
      if (t.tile_present && pix_idx != trlc_pkg::IDX_CLEAR) begin
        px.write_enable = 1'b1;
        case (pix_idx)
          trlc_pkg::IDX_ONE: px.pixel_color = t.color_one;
          trlc_pkg::IDX_TWO: px.pixel_color = t.color_two;
          default:           px.pixel_color = t.color_three;
        endcase
      end
      px.last_of_tile = (k + 1 == count);
      px.last_of_line = (k + 1 == count) && line_end;
      pending_pixels.push_back(px);
      if (int'(line_position) > max_position) max_position = int'(line_position);
      line_position = line_position + 1'b1;
    end
    if (line_end) begin
      tile_count    = 0;
      line_position = '0;
    end else begin
      tile_count++;
    end
  endfunction

  // compare one pixel beat with the oldest prediction
  function void check_pixel(trlc_pkg::pixel_t got);
    trlc_pkg::pixel_t want;
    if (pending_pixels.size() == 0) begin
      $error("unexpected pixel beat at position %0d", got.pixel_position);
      errors++;
      return;
    end
    want = pending_pixels.pop_front();
    pixels_checked++;
    if (got.pixel_position !== want.pixel_position) begin
      $error("pixel_position: expected %0d, got %0d", want.pixel_position, got.pixel_position);
      errors++;
    end
    if (got.pixel_color !== want.pixel_color) begin
      $error("pixel_color: expected %0h, got %0h", want.pixel_color, got.pixel_color);
      errors++;
    end
    if (got.write_enable !== want.write_enable) begin
      $error("write_enable: expected %0b, got %0b", want.write_enable, got.write_enable);
      errors++;
    end
    if (got.last_of_tile !== want.last_of_tile) begin
      $error("last_of_tile: expected %0b, got %0b", want.last_of_tile, got.last_of_tile);
      errors++;
    end
    if (got.last_of_line !== want.last_of_line) begin
      $error("last_of_line: expected %0b, got %0b", want.last_of_line, got.last_of_line);
      errors++;
    end
  endfunction
endclass

module tile_row_line_composer_tb;
  import trlc_pkg::*;

  localparam int RANDOM_TILES = 360;
  localparam int CALM_TILES   = 40;
  localparam int DRAIN_LIMIT  = 20000;

  logic                  clk = 1'b0;
  logic                  rst;
  logic                  tile_valid;
  logic                  tile_stall;
  tile_t                 tile_beat;
  logic                  pixel_valid;
  logic                  pixel_stall = 1'b0;
  pixel_t                pixel_beat;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  line_scoreboard line_check = new();
  bit             gaps_on    = 1'b0;
  int             settings_used = 0;

  tile_row_line_composer uut (
    .clk         (clk),
    .rst         (rst),
    .tile_valid  (tile_valid),
    .tile_stall  (tile_stall),
    .tile_beat   (tile_beat),
    .pixel_valid (pixel_valid),
    .pixel_stall (pixel_stall),
    .pixel_beat  (pixel_beat),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data)
  );

  always #5 clk = ~clk;

  // receiver side: stall in short random bursts
  int stall_left = 0;
  always @(negedge clk) begin
    if (stall_left > 0) begin
      pixel_stall = 1'b1;
      stall_left--;
    end else if (gaps_on && $urandom_range(0, 5) == 0) begin
      pixel_stall = 1'b1;
      stall_left  = $urandom_range(0, 4);
    end else begin
      pixel_stall = 1'b0;
    end
  end

  // check every accepted pixel beat
  always @(posedge clk) begin
    if (!rst && pixel_valid && !pixel_stall) begin
      line_check.check_pixel(pixel_beat);
    end
  end

  function automatic tile_t pack_tile(bit present, logic [ROW_W-1:0] row,
                                      logic [COLOR_W-1:0] c1, logic [COLOR_W-1:0] c2,
                                      logic [COLOR_W-1:0] c3);
    tile_t t;
    t.tile_present = present;
    t.pixel_row    = row;
    t.color_one    = c1;
    t.color_two    = c2;
    t.color_three  = c3;
    return t;
  endfunction

  function automatic tile_t random_tile();
    logic [ROW_W-1:0] row;
    case ($urandom_range(0, 9))
      0:       row = '0;
      1:       row = '1;
      default: row = ROW_W'($urandom);
    endcase
    return pack_tile($urandom_range(0, 3) != 0, row, COLOR_W'($urandom),
                     COLOR_W'($urandom), COLOR_W'($urandom));
  endfunction

  // present one tile beat, hold it until accepted; returns at the next falling edge
  task automatic send_tile(input tile_t t);
    int gap;
    if (gaps_on && $urandom_range(0, 4) == 0) begin
      gap = $urandom_range(1, 5);
      tile_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    tile_valid = 1'b1;
    tile_beat  = t;
    @(posedge clk);
    while (tile_stall) @(posedge clk);
    line_check.add_tile(t);
    @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int value);
    cfg_we    = 1'b1;
    cfg_index = idx;
    cfg_data  = CFG_DATA_W'(value);
    @(posedge clk);
    line_check.set_reg(idx, CFG_DATA_W'(value));
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  // sender holds off until every predicted pixel beat has come out
  task automatic wait_drained();
    tile_valid = 1'b0;
    while (line_check.pending_pixels.size() != 0) @(posedge clk);
    @(negedge clk);
  endtask

  // idle point for register writes
  task automatic settle();
    wait_drained();
    repeat (4) @(negedge clk);
    settings_used++;
  endtask

  initial begin
    int fs_val;
    int lt_val;
    int phase_tiles;
    int random_sent;
    int phase_count;
    int drain_cycles;
    bit phase_gaps;

    rst        = 1'b1;
    tile_valid = 1'b0;
    tile_beat  = '0;
    cfg_we     = 1'b0;
    cfg_index  = '0;
    cfg_data   = '0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    @(negedge clk);

    // directed: three-tile line with scroll 3, transparent and absent tiles
    write_reg(REG_FINE_SCROLL, 3);
    write_reg(REG_LINE_TILES, 2);
    send_tile(pack_tile(1'b1, 16'h0000, 8'h11, 8'h22, 8'h33));
    send_tile(pack_tile(1'b1, 16'hE4E4, 8'h00, 8'hFF, 8'h5A));
    send_tile(pack_tile(1'b0, 16'hFFFF, 8'hFF, 8'hFF, 8'hFF));
    send_tile(pack_tile(1'b1, 16'hFFFF, 8'hFF, 8'hFF, 8'hFF));
    send_tile(pack_tile(1'b1, 16'h5555, 8'hA5, 8'h00, 8'h00));
    send_tile(pack_tile(1'b1, 16'hAAAA, 8'h00, 8'h3C, 8'h00));
    settle();

    // widest scroll: one pixel from the first tile, seven from the extra one
    write_reg(REG_FINE_SCROLL, 7);
    write_reg(REG_LINE_TILES, 1);
    send_tile(pack_tile(1'b1, 16'h1B1B, 8'h01, 8'h02, 8'h03));
    send_tile(pack_tile(1'b1, 16'hC6C6, 8'hFE, 8'h7F, 8'h80));
    send_tile(pack_tile(1'b0, 16'h0000, 8'h00, 8'h00, 8'h00));
    send_tile(pack_tile(1'b1, 16'hFFFF, 8'h00, 8'h00, 8'hFF));
    settle();

    // zero line length counts as one tile
    write_reg(REG_FINE_SCROLL, 0);
    write_reg(REG_LINE_TILES, 0);
    send_tile(pack_tile(1'b1, 16'h39E4, 8'h10, 8'h20, 8'h30));
    send_tile(pack_tile(1'b1, 16'h9C27, 8'hEF, 8'hDF, 8'hBF));
    settle();

    // stop partway through a line, then shorten it so the next tile restarts
    write_reg(REG_LINE_TILES, 4);
    send_tile(pack_tile(1'b1, 16'h0123, 8'h44, 8'h55, 8'h66));
    send_tile(pack_tile(1'b1, 16'h4567, 8'h77, 8'h88, 8'h99));
    send_tile(pack_tile(1'b1, 16'h89AB, 8'hAA, 8'hBB, 8'hCC));
    settle();
    write_reg(REG_LINE_TILES, 2);
    send_tile(pack_tile(1'b1, 16'hCDEF, 8'hDD, 8'hEE, 8'hF0));
    send_tile(pack_tile(1'b1, 16'hFEDC, 8'h0F, 8'h1E, 8'h2D));
    settle();
    write_reg(REG_FINE_SCROLL, 5 | (15 << FS_W));
    send_tile(pack_tile(1'b1, 16'hBA98, 8'h3C, 8'h4B, 8'h5A));
    settle();

    // random phases, each under its own register setting
    random_sent = 0;
    phase_count = 0;
    while (random_sent < RANDOM_TILES) begin
      case (phase_count)
        0: begin fs_val = 7; lt_val = 64;  end
        1: begin fs_val = 0; lt_val = 127; end
        2: begin fs_val = 1; lt_val = 100; end
        default: begin
          fs_val = $urandom_range(0, 7);
          case ($urandom_range(0, 9))
            0:       lt_val = 0;
            1:       lt_val = $urandom_range(9, 127);
            default: lt_val = $urandom_range(1, 8);
          endcase
        end
      endcase
      write_reg(REG_FINE_SCROLL, fs_val | ($urandom_range(0, 15) << FS_W));
      write_reg(REG_LINE_TILES, lt_val);
      if (phase_count < 3) begin
        phase_tiles = 66;
      end else begin
        phase_tiles = $urandom_range(1, 3 * ((lt_val > 8) ? 9 : lt_val + 1));
      end
      phase_gaps = ($urandom_range(0, 3) != 0);
      for (int i = 0; i < phase_tiles && random_sent < RANDOM_TILES; i++) begin
        gaps_on = phase_gaps && (random_sent < RANDOM_TILES - CALM_TILES);
        if ((phase_count == 0 && i == 3) || $urandom_range(0, 39) == 0) begin
          wait_drained();
        end
        send_tile(random_tile());
        random_sent++;
      end
      settle();
      phase_count++;
    end

    // wait out the tail
    tile_valid = 1'b0;
    gaps_on    = 1'b0;
    drain_cycles = 0;
    while (line_check.pending_pixels.size() != 0 && drain_cycles < DRAIN_LIMIT) begin
      @(posedge clk);
      drain_cycles++;
    end
    if (line_check.pending_pixels.size() != 0) begin
      $error("%0d pixel beats never arrived", line_check.pending_pixels.size());
      line_check.errors += line_check.pending_pixels.size();
    end
    repeat (20) @(posedge clk);

    $display("run covered %0d tiles under %0d register settings",
             line_check.tiles_seen, settings_used);
    $display("%0d pixel beats checked, highest line position %0d",
             line_check.pixels_checked, line_check.max_position);
    if (line_check.errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  // hard stop if the handshakes hang
  initial begin
    #3000000;
    $display("status: fail");
    $finish;
  end

endmodule
